### rtl/compare_timer_with_prescale_select_core_macros.svh
// Assertion macros for the prescaled compare timer core.
// Used by modules that carry clk_i and rst_ni; no other dependencies.
`ifndef COMPARE_TIMER_WITH_PRESCALE_SELECT_CORE_MACROS_SVH
`define COMPARE_TIMER_WITH_PRESCALE_SELECT_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CTPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/ctps_pkg.sv
// Shared types, codes and a helper function for the prescaled compare timer.
// No dependencies.
package ctps_pkg;

  // Prescale exponent range and trailing-zero cap
  localparam logic [3:0] BasePrescale = 4'd4;
  localparam logic [2:0] MaxTz        = 3'd5;

  // Input item codes
  typedef enum logic [1:0] {
    OP_PROGRAM = 2'd0,
    OP_TICK    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IRQ_ENABLE       = 2'd0,
    REG_CLEAR_ON_COMPARE = 2'd1,
    REG_STOP_ON_COMPARE  = 2'd2
  } reg_idx_e;

  // Counter width codes
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_24 = 2'd2,
    WIDTH_32 = 2'd3
  } width_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] duration_us;
  } in_word_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic        is_running;
    logic        compare_event;
    logic        irq_out;
    logic [3:0]  prescale_code;
    logic [31:0] compare_value;
    logic [1:0]  width_code;
  } out_word_t;

  // Counter wrap mask for a width code
  function automatic logic [31:0] width_mask(input logic [1:0] sel);
    logic [31:0] m;
    unique case (width_e'(sel))
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      WIDTH_24: m = 32'h00FF_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/compare_timer_with_prescale_select_core.sv
// Prescaled one-shot compare timer core: state update and result register.
// Depends on ctps_pkg and compare_timer_with_prescale_select_core_macros.svh.
`include "compare_timer_with_prescale_select_core_macros.svh"

// One word in, one word out. Every accepted word (program, base tick or event
// clear) updates the timer state in the cycle it is accepted and its result
// word appears on the output register in the next cycle. A new word is taken
// every cycle as long as the result register is empty or is being drained in
// the same cycle, so the block sustains one word per clock; the only limit is
// the single-entry output register, which stalls the input only while the
// downstream side holds off. While running, the timer counts once every
// 2^prescale_code accepted tick words, wraps at the selected width and flags a
// match with the compare value; configuration writes take effect at once.
module compare_timer_with_prescale_select_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ctps_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ctps_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_wdata_i
);

  // Configuration
  logic irq_enable_q, clear_on_compare_q, stop_on_compare_q;

  // Timer state
  logic [31:0] counter_q, counter_d;
  logic [8:0]  divider_q, divider_d;
  logic [3:0]  prescale_q, prescale_d;
  logic [31:0] compare_q, compare_d;
  logic [1:0]  width_q, width_d;
  logic        running_q, running_d;
  logic        event_q, event_d;

  // Result register
  logic                out_valid_q;
  ctps_pkg::out_word_t out_q, out_d;

  logic        accept;
  logic [2:0]  tz;
  logic [31:0] cmp_new;
  logic [8:0]  div_last;
  logic [31:0] cnt_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_enable_q       <= 1'b0;
      clear_on_compare_q <= 1'b1;
      stop_on_compare_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (ctps_pkg::reg_idx_e'(cfg_index_i))
        ctps_pkg::REG_IRQ_ENABLE:       irq_enable_q       <= cfg_wdata_i;
        ctps_pkg::REG_CLEAR_ON_COMPARE: clear_on_compare_q <= cfg_wdata_i;
        ctps_pkg::REG_STOP_ON_COMPARE:  stop_on_compare_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Count trailing zeros of the duration, capped
  always_comb begin
    priority casez (in_word_i.duration_us[4:0])
      5'b????1: tz = 3'd0;
      5'b???10: tz = 3'd1;
      5'b??100: tz = 3'd2;
      5'b?1000: tz = 3'd3;
      5'b10000: tz = 3'd4;
      default:  tz = ctps_pkg::MaxTz;
    endcase
  end

  assign cmp_new = in_word_i.duration_us >> tz;

  // Divider terminal value; prescale above the cap counts as the cap
  always_comb begin
    logic [3:0] p;
    p = prescale_q;
    if (p > ctps_pkg::BasePrescale + 4'(ctps_pkg::MaxTz)) begin
      p = ctps_pkg::BasePrescale + 4'(ctps_pkg::MaxTz);
    end
    div_last = 9'((10'd1 << p) - 10'd1);
  end

  assign cnt_inc = (counter_q + 32'd1) & ctps_pkg::width_mask(width_q);

  // Next timer state for the accepted word
  always_comb begin
    counter_d  = counter_q;
    divider_d  = divider_q;
    prescale_d = prescale_q;
    compare_d  = compare_q;
    width_d    = width_q;
    running_d  = running_q;
    event_d    = event_q;
    unique case (ctps_pkg::op_e'(in_word_i.op))
      ctps_pkg::OP_PROGRAM: begin
        prescale_d = ctps_pkg::BasePrescale + 4'(tz);
        compare_d  = cmp_new;
        if (cmp_new[31:8] == 24'd0) begin
          width_d = ctps_pkg::WIDTH_8;
        end else if (cmp_new[31:16] == 16'd0) begin
          width_d = ctps_pkg::WIDTH_16;
        end else if (cmp_new[31:24] == 8'd0) begin
          width_d = ctps_pkg::WIDTH_24;
        end else begin
          width_d = ctps_pkg::WIDTH_32;
        end
        counter_d = '0;
        divider_d = '0;
        running_d = 1'b1;
      end
      ctps_pkg::OP_TICK: begin
        if (running_q) begin
          if (divider_q < div_last) begin
            divider_d = divider_q + 9'd1;
          end else begin
            divider_d = '0;
            counter_d = cnt_inc;
            if (cnt_inc == compare_q) begin
              event_d = 1'b1;
              if (clear_on_compare_q) counter_d = '0;
              if (stop_on_compare_q)  running_d = 1'b0;
            end
          end
        end
      end
      ctps_pkg::OP_CLEAR: begin
        event_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Update timer state on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= '0;
      divider_q  <= '0;
      prescale_q <= ctps_pkg::BasePrescale;
      compare_q  <= '0;
      width_q    <= ctps_pkg::WIDTH_32;
      running_q  <= 1'b0;
      event_q    <= 1'b0;
    end else if (accept) begin
      counter_q  <= counter_d;
      divider_q  <= divider_d;
      prescale_q <= prescale_d;
      compare_q  <= compare_d;
      width_q    <= width_d;
      running_q  <= running_d;
      event_q    <= event_d;
    end
  end

  // Assemble the result word from the new state
  always_comb begin
    out_d.count_value   = counter_d;
    out_d.is_running    = running_d;
    out_d.compare_event = event_d;
    out_d.irq_out       = event_d && irq_enable_q;
    out_d.prescale_code = prescale_d;
    out_d.compare_value = compare_d;
    out_d.width_code    = width_d;
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `CTPS_ASSERT(a_accept_gives_result, accept |=> out_valid_o,
               "accepted word produced no result")
  `CTPS_ASSERT(a_irq_needs_event, out_valid_o && out_word_o.irq_out |-> out_word_o.compare_event,
               "interrupt without compare event")
  `CTPS_ASSERT(a_count_in_width,
               out_valid_o |-> ((out_word_o.count_value
                                 & ~ctps_pkg::width_mask(out_word_o.width_code)) == 32'd0),
               "counter exceeds selected width")
  `CTPS_ASSERT(a_prescale_range,
               (prescale_q >= ctps_pkg::BasePrescale)
               && (prescale_q <= ctps_pkg::BasePrescale + 4'(ctps_pkg::MaxTz)),
               "prescale out of range")
  `CTPS_ASSERT_ALWAYS(a_idle_after_reset, !rst_ni |=> !out_valid_o,
                      "result valid right after reset")

endmodule

### tb/testbench.sv
// Self-checking testbench for the prescaled one-shot compare timer core.
// Depends on ctps_pkg and compare_timer_with_prescale_select_core; drives words
// through valid/ready channels and checks every result against a timer model.
`timescale 1ns / 100ps

module testbench;

  // Codes outside the package enums, used to hit the unused slots
  localparam logic [1:0] OpUnused  = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;

  logic      clk         = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  ctps_pkg::in_word_t  in_word = '0;
  logic      out_ready   = 1'b0;
  logic      cfg_we      = 1'b0;
  logic [1:0] cfg_index  = 2'd0;
  logic      cfg_wdata   = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  ctps_pkg::out_word_t out_word_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;

  ctps_pkg::out_word_t timer_results[$];

  // Timer model state, reset values
  logic [31:0] tmr_count      = 32'd0;
  logic [8:0]  tmr_div        = 9'd0;
  logic [3:0]  tmr_prescale   = ctps_pkg::BasePrescale;
  logic [31:0] tmr_compare    = 32'd0;
  logic [1:0]  tmr_width      = ctps_pkg::WIDTH_32;
  logic        tmr_running    = 1'b0;
  logic        tmr_event      = 1'b0;
  logic        irq_en         = 1'b0;
  logic        clear_on_match = 1'b1;
  logic        stop_on_match  = 1'b1;

  compare_timer_with_prescale_select_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the timer model by one word and return the state it reports
  function automatic ctps_pkg::out_word_t step_timer(input ctps_pkg::in_word_t w);
    ctps_pkg::out_word_t r;
    logic [2:0]  tz;
    logic [9:0]  last;
    logic [31:0] wrap;
    case (w.op)
      ctps_pkg::OP_PROGRAM: begin
        tz = 3'd0;
        while (tz < ctps_pkg::MaxTz && !w.duration_us[tz]) tz++;
        tmr_prescale = ctps_pkg::BasePrescale + 4'(tz);
        tmr_compare  = w.duration_us >> tz;
        if (tmr_compare <= 32'h0000_00FF) tmr_width = ctps_pkg::WIDTH_8;
        else if (tmr_compare <= 32'h0000_FFFF) tmr_width = ctps_pkg::WIDTH_16;
        else if (tmr_compare <= 32'h00FF_FFFF) tmr_width = ctps_pkg::WIDTH_24;
        else tmr_width = ctps_pkg::WIDTH_32;
        tmr_count   = 32'd0;
        tmr_div     = 9'd0;
        tmr_running = 1'b1;
      end
      ctps_pkg::OP_TICK: begin
        if (tmr_running) begin
          last = (10'd1 << tmr_prescale) - 10'd1;
          if ({1'b0, tmr_div} < last) begin
            tmr_div = tmr_div + 9'd1;
          end else begin
            tmr_div = 9'd0;
            case (tmr_width)
              ctps_pkg::WIDTH_8:  wrap = 32'h0000_00FF;
              ctps_pkg::WIDTH_16: wrap = 32'h0000_FFFF;
              ctps_pkg::WIDTH_24: wrap = 32'h00FF_FFFF;
              default:            wrap = 32'hFFFF_FFFF;
            endcase
            tmr_count = (tmr_count + 32'd1) & wrap;
            if (tmr_count == tmr_compare) begin
              tmr_event = 1'b1;
              if (clear_on_match) tmr_count = 32'd0;
              if (stop_on_match) tmr_running = 1'b0;
            end
          end
        end
      end
      ctps_pkg::OP_CLEAR: tmr_event = 1'b0;
      default: ;
    endcase
    r.count_value   = tmr_count;
    r.is_running    = tmr_running;
    r.compare_event = tmr_event;
    r.irq_out       = tmr_event & irq_en;
    r.prescale_code = tmr_prescale;
    r.compare_value = tmr_compare;
    r.width_code    = tmr_width;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  // Check drained words, track register writes, predict accepted words
  always @(posedge clk) begin
    ctps_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (timer_results.size() == 0) begin
          $error("result word with no expected word pending");
          mismatches++;
        end else begin
          want = timer_results.pop_front();
          check_field("count_value", want.count_value, out_word_o.count_value);
          check_field("is_running", 32'(want.is_running), 32'(out_word_o.is_running));
          check_field("compare_event", 32'(want.compare_event),
                      32'(out_word_o.compare_event));
          check_field("irq_out", 32'(want.irq_out), 32'(out_word_o.irq_out));
          check_field("prescale_code", 32'(want.prescale_code),
                      32'(out_word_o.prescale_code));
          check_field("compare_value", want.compare_value, out_word_o.compare_value);
          check_field("width_code", 32'(want.width_code), 32'(out_word_o.width_code));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ctps_pkg::REG_IRQ_ENABLE:       irq_en = cfg_wdata;
          ctps_pkg::REG_CLEAR_ON_COMPARE: clear_on_match = cfg_wdata;
          ctps_pkg::REG_STOP_ON_COMPARE:  stop_on_match = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) timer_results.push_back(step_timer(in_word));
    end
  end

  // Drive downstream ready: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_left = HoldCycles;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Offer one word, with random gaps before it, and hold it until accepted
  task automatic send_word(input logic [1:0] op, input logic [31:0] dur);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_word.op          = op;
    in_word.duration_us = dur;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (timer_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(input logic irq, input logic clr, input logic stop);
    write_reg(ctps_pkg::REG_IRQ_ENABLE, irq);
    write_reg(ctps_pkg::REG_CLEAR_ON_COMPARE, clr);
    write_reg(ctps_pkg::REG_STOP_ON_COMPARE, stop);
  endtask

  // Clear, unused op and tick on a stopped timer leave reset state alone
  task automatic test_reset_values();
    send_word(ctps_pkg::OP_CLEAR, 32'd0);
    send_word(OpUnused, 32'hFFFF_FFFF);
    send_word(ctps_pkg::OP_TICK, 32'h5A5A_5A5A);
  endtask

  // Match with and without the interrupt, stop on match, event clear
  task automatic test_match_irq();
    write_reg(ctps_pkg::REG_IRQ_ENABLE, 1'b1);
    write_reg(RegUnused, 1'b1);
    send_word(ctps_pkg::OP_PROGRAM, 32'd1);
    repeat (17) send_word(ctps_pkg::OP_TICK, $urandom);
    send_word(ctps_pkg::OP_CLEAR, 32'd0);
    write_reg(ctps_pkg::REG_IRQ_ENABLE, 1'b0);
    send_word(ctps_pkg::OP_PROGRAM, 32'd1);
    repeat (16) send_word(ctps_pkg::OP_TICK, $urandom);
  endtask

  // Width boundaries, trailing-zero cap, reprogram while running
  task automatic test_program_widths();
    logic [31:0] durs[14];
    durs = '{32'h0000_00FF, 32'h0000_0100, 32'h0000_0101, 32'h0000_FFFF,
             32'h0001_0001, 32'h00FF_FFFF, 32'h0100_0001, 32'hFFFF_FFFF,
             32'h8000_0000, 32'h0000_0020, 32'h0000_0002, 32'h0000_0004,
             32'h0000_0008, 32'h0000_0010};
    foreach (durs[i]) begin
      send_word(ctps_pkg::OP_PROGRAM, durs[i]);
      if (i % 4 == 0) send_word(ctps_pkg::OP_TICK, 32'd0);
    end
  endtask

  // Free run past the compare value with clear and stop on match off
  task automatic test_free_run_wrap();
    set_config(1'b1, 1'b0, 1'b0);
    send_word(ctps_pkg::OP_PROGRAM, 32'd3);
    repeat (100) send_word(ctps_pkg::OP_TICK, $urandom);
    send_word(ctps_pkg::OP_CLEAR, 32'd0);
  endtask

  // Zero duration loads an 8-bit zero compare with the capped prescale
  task automatic test_zero_duration();
    set_config(1'b0, 1'b1, 1'b1);
    send_word(ctps_pkg::OP_PROGRAM, 32'd0);
    repeat (40) send_word(ctps_pkg::OP_TICK, $urandom);
  endtask

  // Hold off downstream long enough to fill the block and stall its input
  task automatic test_backpressure();
    hold_req++;
    repeat (30) send_word(2'($urandom_range(0, 3)), $urandom);
  endtask

  // Program short durations followed by tick runs, mixed with random noise
  task automatic run_random_timer_traffic(input int n_words);
    int          sent;
    int          run_len;
    int          roll;
    int          tz;
    logic [31:0] dur;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 75) begin
        tz  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
        dur = (($urandom_range(0, 3) == 0) ? 32'd3 : 32'd1) << tz;
        send_word(ctps_pkg::OP_PROGRAM, dur);
        sent++;
        run_len = $urandom_range(16, 80);
        for (int i = 0; i < run_len && sent < n_words; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 4) send_word(ctps_pkg::OP_CLEAR, $urandom);
          else if (roll < 6) send_word(OpUnused, $urandom);
          else send_word(ctps_pkg::OP_TICK, $urandom);
          sent++;
        end
      end else begin
        run_len = $urandom_range(1, 6);
        for (int i = 0; i < run_len && sent < n_words; i++) begin
          send_word(2'($urandom_range(0, 3)), $urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 50;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_reset_values();
    test_match_irq();
    test_program_widths();
    set_config(1'b1, 1'b1, 1'b1);
    run_random_timer_traffic(180);

    send_idle_pct = 50;
    recv_idle_pct = 28;
    test_free_run_wrap();
    set_config(1'b0, 1'b0, 1'b1);
    run_random_timer_traffic(180);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_zero_duration();
    test_backpressure();
    set_config(1'b1, 1'b1, 1'b0);
    run_random_timer_traffic(120);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
